// ===== rtl/dbf_pkg.sv =====
package dbf_pkg;

  // Field widths of the row and result items.
  localparam int COORD_W         = 16;
  localparam int SCORE_W         = 16;
  localparam int CLASS_VAL_W     = 12;
  localparam int CLASS_ID_W      = 9;
  localparam int CLASS_FRAC_BITS = 4;
  localparam int CLASS_MAX       = 255;

  // Configuration register widths.
  localparam int SCALE_W      = 24;
  localparam int SCALE_FRAC_W = 16;
  localparam int PIXEL_W      = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  // Default number of fraction bits on coordinates.
  localparam int COORD_FRAC_BITS_DEF = 4;

  // Scaled edge after dropping the scale fraction, and the width that holds
  // an edge plus offset plus size without overflow.
  localparam int PROD_W = COORD_W + SCALE_W + 1;
  localparam int SC_W   = PROD_W - SCALE_FRAC_W;
  localparam int WIDE_W = SC_W + 1;

  // Row queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_LIMIT   = 3'd0,
    REG_INVERSE_SCALE = 3'd1,
    REG_OFFSET_X      = 3'd2,
    REG_OFFSET_Y      = 3'd3,
    REG_IMAGE_WIDTH   = 3'd4,
    REG_IMAGE_HEIGHT  = 3'd5,
    REG_SINGLE_CLASS  = 3'd6
  } dbf_reg_e;

  typedef struct packed {
    logic [SCORE_W-1:0] score_limit;
    logic [SCALE_W-1:0] inverse_scale;
    logic [PIXEL_W-1:0] offset_x;
    logic [PIXEL_W-1:0] offset_y;
    logic [PIXEL_W-1:0] image_width;
    logic [PIXEL_W-1:0] image_height;
    logic               single_class;
  } dbf_cfg_t;

  // A classified row as handed from front to back.
  typedef struct packed {
    logic                         last;
    logic                         ok;
    logic signed [COORD_W-1:0]    left;
    logic signed [COORD_W-1:0]    top;
    logic [COORD_W-1:0]           size_w;
    logic [COORD_W-1:0]           size_h;
    logic [SCORE_W-1:0]           score;
    logic signed [CLASS_ID_W-1:0] label_id;
  } dbf_row_t;

  typedef struct packed {
    logic                         found;
    logic signed [CLASS_ID_W-1:0] label_id;
    logic [SCORE_W-1:0]           confidence;
    logic [COORD_W-1:0]           box_left;
    logic [COORD_W-1:0]           box_top;
    logic [COORD_W-1:0]           box_width;
    logic [COORD_W-1:0]           box_height;
    logic [COORD_W-1:0]           center_x;
    logic [COORD_W-1:0]           center_y;
  } dbf_result_t;

endpackage

// ===== rtl/dbf_front.sv =====
module dbf_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  dbf_pkg::dbf_cfg_t                       cfg_i,
  input  logic                                    row_valid_i,
  output logic                                    row_ready_o,
  input  logic signed [dbf_pkg::COORD_W-1:0]      corner_x1_i,
  input  logic signed [dbf_pkg::COORD_W-1:0]      corner_y1_i,
  input  logic signed [dbf_pkg::COORD_W-1:0]      corner_x2_i,
  input  logic signed [dbf_pkg::COORD_W-1:0]      corner_y2_i,
  input  logic [dbf_pkg::SCORE_W-1:0]             score_i,
  input  logic [dbf_pkg::CLASS_VAL_W-1:0]         class_value_i,
  input  logic                                    last_row_i,
  output logic                                    push_valid_o,
  input  logic                                    push_ready_i,
  output dbf_pkg::dbf_row_t                       push_row_o
);
  import dbf_pkg::*;

  localparam int RND_W = CLASS_VAL_W + 1;

  logic                      valid_q, valid_d;
  dbf_row_t                  row_q, row_d;
  logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [COORD_W:0]          diff_x, diff_y;
  logic [RND_W-1:0]          cls_rnd;
  logic [CLASS_ID_W-1:0]     cls_int;

  assign row_ready_o  = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;
  assign push_row_o   = row_q;

  // Order the corners, check the score and the scale, and round the class.
  always_comb begin
    lo_x    = (corner_x1_i < corner_x2_i) ? corner_x1_i : corner_x2_i;
    hi_x    = (corner_x1_i < corner_x2_i) ? corner_x2_i : corner_x1_i;
    lo_y    = (corner_y1_i < corner_y2_i) ? corner_y1_i : corner_y2_i;
    hi_y    = (corner_y1_i < corner_y2_i) ? corner_y2_i : corner_y1_i;
    diff_x  = {{1{hi_x[COORD_W-1]}}, hi_x} - {{1{lo_x[COORD_W-1]}}, lo_x};
    diff_y  = {{1{hi_y[COORD_W-1]}}, hi_y} - {{1{lo_y[COORD_W-1]}}, lo_y};
    cls_rnd = {1'b0, class_value_i} + RND_W'(1 << (CLASS_FRAC_BITS - 1));
    cls_int = CLASS_ID_W'(cls_rnd >> CLASS_FRAC_BITS);
    if (cls_int > CLASS_ID_W'(CLASS_MAX)) begin
      cls_int = CLASS_ID_W'(CLASS_MAX);
    end

    row_d.last     = last_row_i;
    row_d.ok       = (cfg_i.inverse_scale != '0) && (score_i >= cfg_i.score_limit);
    row_d.left     = lo_x;
    row_d.top      = lo_y;
    row_d.size_w   = diff_x[COORD_W-1:0];
    row_d.size_h   = diff_y[COORD_W-1:0];
    row_d.score    = score_i;
    row_d.label_id = cfg_i.single_class ? '1 : $signed(cls_int);
  end

  // Input register: a row moves on when the queue takes it.
  always_comb begin
    valid_d = valid_q;
    if (row_ready_o) begin
      valid_d = row_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_ready_o && row_valid_i) begin
      row_q <= row_d;
    end
  end

endmodule

// ===== rtl/dbf_queue.sv =====
module dbf_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  dbf_pkg::dbf_row_t push_row_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output dbf_pkg::dbf_row_t pop_row_o
);
  import dbf_pkg::*;

  dbf_row_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]     count_q, count_d;
  logic                  push, pop;

  assign push_ready_o = (count_q != (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_row_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_row_i;
    end
  end

endmodule

// ===== rtl/dbf_back.sv =====
module dbf_back #(
  parameter int COORD_FRAC_BITS = dbf_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dbf_pkg::dbf_cfg_t    cfg_i,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  dbf_pkg::dbf_row_t    pop_row_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output dbf_pkg::dbf_result_t res_o
);
  import dbf_pkg::*;

  localparam int LIM_W = PIXEL_W + COORD_FRAC_BITS;

  // Row fields that ride along the pipeline unchanged.
  typedef struct packed {
    logic                         last;
    logic                         ok;
    logic [SCORE_W-1:0]           score;
    logic signed [CLASS_ID_W-1:0] label_id;
  } dbf_tag_t;

  logic adv;

  logic                     v1_q, v2_q, v3_q, v4_q, out_v_q, out_v_d;
  dbf_tag_t                 tag1_q, tag2_q, tag3_q, tag4_q;
  logic signed [PROD_W-1:0] pl_q, pt_q;
  logic [PROD_W-2:0]        pw_q, ph_q;
  logic signed [WIDE_W-1:0] sl_q, st_q, sw_q, sh_q;
  logic signed [WIDE_W-1:0] cl_q, ct_q, el_q, et_q;
  logic signed [WIDE_W-1:0] bl_q, bt_q, bw_q, bh_q;
  logic                     fd_q, fd_d;
  dbf_result_t              res_q, res_d;

  logic signed [WIDE_W-1:0] off_x, off_y, lim_x, lim_y, one_w;
  logic signed [WIDE_W-1:0] cl_d, ct_d, el_d, et_d;
  logic [LIM_W-1:0]         lim_xu, lim_yu;

  // The whole pipeline moves when the output register is free or drained.
  assign adv         = !out_v_q || res_ready_i;
  assign pop_ready_o = adv;
  assign res_valid_o = out_v_q;
  assign res_o       = res_q;

  assign lim_xu = LIM_W'(cfg_i.image_width) << COORD_FRAC_BITS;
  assign lim_yu = LIM_W'(cfg_i.image_height) << COORD_FRAC_BITS;
  assign lim_x  = $signed(WIDE_W'(lim_xu));
  assign lim_y  = $signed(WIDE_W'(lim_yu));
  assign off_x  = $signed(WIDE_W'(cfg_i.offset_x) << COORD_FRAC_BITS);
  assign off_y  = $signed(WIDE_W'(cfg_i.offset_y) << COORD_FRAC_BITS);
  assign one_w  = $signed(WIDE_W'(1) << COORD_FRAC_BITS);

  // Clip start and end of each axis to the image.
  always_comb begin
    cl_d = (sl_q < lim_x) ? sl_q : lim_x;
    if (cl_d < 0) begin
      cl_d = '0;
    end
    el_d = sl_q + sw_q;
    if (el_d > lim_x) begin
      el_d = lim_x;
    end
    if (el_d < cl_d) begin
      el_d = cl_d;
    end
    ct_d = (st_q < lim_y) ? st_q : lim_y;
    if (ct_d < 0) begin
      ct_d = '0;
    end
    et_d = st_q + sh_q;
    if (et_d > lim_y) begin
      et_d = lim_y;
    end
    if (et_d < ct_d) begin
      et_d = ct_d;
    end
  end

  // Final decision: first surviving box of a frame, or not found at its end.
  always_comb begin
    logic signed [WIDE_W-1:0] cx, cy;
    cx      = bl_q + (bw_q >>> 1);
    cy      = bt_q + (bh_q >>> 1);
    fd_d    = fd_q;
    out_v_d = out_v_q;
    res_d   = res_q;
    if (adv) begin
      out_v_d = 1'b0;
      if (v4_q) begin
        if (fd_q) begin
          fd_d = !tag4_q.last;
        end else if (tag4_q.ok && (bw_q > one_w) && (bh_q > one_w)) begin
          out_v_d          = 1'b1;
          fd_d             = !tag4_q.last;
          res_d.found      = 1'b1;
          res_d.label_id   = tag4_q.label_id;
          res_d.confidence = tag4_q.score;
          res_d.box_left   = bl_q[COORD_W-1:0];
          res_d.box_top    = bt_q[COORD_W-1:0];
          res_d.box_width  = bw_q[COORD_W-1:0];
          res_d.box_height = bh_q[COORD_W-1:0];
          res_d.center_x   = cx[COORD_W-1:0];
          res_d.center_y   = cy[COORD_W-1:0];
        end else if (tag4_q.last) begin
          out_v_d = 1'b1;
          res_d   = '0;
        end
      end
    end
  end

  // Stage valid bits, frame state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
      fd_q    <= 1'b0;
    end else begin
      if (adv) begin
        v1_q <= pop_valid_i;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
      end
      out_v_q <= out_v_d;
      fd_q    <= fd_d;
    end
  end

  // Datapath: scale, offset, clip, length.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (adv) begin
      tag1_q.last     <= pop_row_i.last;
      tag1_q.ok       <= pop_row_i.ok;
      tag1_q.score    <= pop_row_i.score;
      tag1_q.label_id <= pop_row_i.label_id;
      pl_q <= PROD_W'(pop_row_i.left * $signed({1'b0, cfg_i.inverse_scale}));
      pt_q <= PROD_W'(pop_row_i.top * $signed({1'b0, cfg_i.inverse_scale}));
      pw_q <= (PROD_W - 1)'(pop_row_i.size_w * cfg_i.inverse_scale);
      ph_q <= (PROD_W - 1)'(pop_row_i.size_h * cfg_i.inverse_scale);

      tag2_q <= tag1_q;
      sl_q   <= WIDE_W'(pl_q >>> SCALE_FRAC_W) + off_x;
      st_q   <= WIDE_W'(pt_q >>> SCALE_FRAC_W) + off_y;
      sw_q   <= $signed(WIDE_W'(pw_q >> SCALE_FRAC_W));
      sh_q   <= $signed(WIDE_W'(ph_q >> SCALE_FRAC_W));

      tag3_q <= tag2_q;
      cl_q   <= cl_d;
      ct_q   <= ct_d;
      el_q   <= el_d;
      et_q   <= et_d;

      tag4_q <= tag3_q;
      bl_q   <= cl_q;
      bt_q   <= ct_q;
      bw_q   <= el_q - cl_q;
      bh_q   <= et_q - ct_q;
    end
  end

endmodule

// ===== rtl/detection_box_filter.sv =====
// Detection box filter.
// Rows of a detector's output enter on the s_axis channel, one row per
// transfer, with tlast on the final row of a frame. Each row has its corners
// ordered, is checked against the score limit, is scaled by the inverse
// scale, shifted by the region offset and clipped to the image. The first box
// of a frame that is wider and taller than one pixel leaves on m_axis with
// tuser high; a frame that ends without one yields a single transfer with
// tuser low and all data zero. Other rows give no transfer.
// Configuration is written on the cfg channel, index and data; the user
// must write it only while no row is in flight; the block does not enforce
// this. cfg_ready_o is always high. Throughput is one row per cycle while
// m_axis does not stall. A row that leads to a result passes, after its
// transfer loads the input register, through the queue, multiply, offset,
// clip, length and output register stages in that order to m_axis.
// When m_axis stalls, the back pipeline holds; the four-entry queue and the
// input register keep taking rows until they fill, then s_axis_tready drops.
// Reset clears the frame state, empties the pipeline and loads the
// configuration defaults.
module detection_box_filter #(
  parameter int COORD_FRAC_BITS = dbf_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dbf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dbf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Row input.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // corner_x1[15:0], corner_y1[31:16], corner_x2[47:32], corner_y2[63:48],
  // score[79:64], class_value[91:80], zero fill[95:92]
  input  logic [dbf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  logic                               s_axis_tlast,
  // Result output.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // label_id[8:0], confidence[24:9], box_left[40:25], box_top[56:41],
  // box_width[72:57], box_height[88:73], center_x[104:89],
  // center_y[120:105], zero fill[127:121]
  output logic [dbf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // found[0]
  output logic                               m_axis_tuser
);
  import dbf_pkg::*;

  dbf_cfg_t    cfg_q, cfg_d;
  dbf_row_t    push_row, pop_row;
  logic        push_valid, push_ready, pop_valid, pop_ready;
  dbf_result_t res;

  assign cfg_ready_o = 1'b1;

  // Configuration register writes.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (dbf_reg_e'(cfg_index_i))
        REG_SCORE_LIMIT:   cfg_d.score_limit   = cfg_data_i[SCORE_W-1:0];
        REG_INVERSE_SCALE: cfg_d.inverse_scale = cfg_data_i[SCALE_W-1:0];
        REG_OFFSET_X:      cfg_d.offset_x      = cfg_data_i[PIXEL_W-1:0];
        REG_OFFSET_Y:      cfg_d.offset_y      = cfg_data_i[PIXEL_W-1:0];
        REG_IMAGE_WIDTH:   cfg_d.image_width   = cfg_data_i[PIXEL_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_d.image_height  = cfg_data_i[PIXEL_W-1:0];
        REG_SINGLE_CLASS:  cfg_d.single_class  = cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_limit   <= SCORE_W'(32768);
      cfg_q.inverse_scale <= SCALE_W'(65536);
      cfg_q.offset_x      <= '0;
      cfg_q.offset_y      <= '0;
      cfg_q.image_width   <= PIXEL_W'(1280);
      cfg_q.image_height  <= PIXEL_W'(1024);
      cfg_q.single_class  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dbf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .row_valid_i   (s_axis_tvalid),
    .row_ready_o   (s_axis_tready),
    .corner_x1_i   ($signed(s_axis_tdata[15:0])),
    .corner_y1_i   ($signed(s_axis_tdata[31:16])),
    .corner_x2_i   ($signed(s_axis_tdata[47:32])),
    .corner_y2_i   ($signed(s_axis_tdata[63:48])),
    .score_i       (s_axis_tdata[79:64]),
    .class_value_i (s_axis_tdata[91:80]),
    .last_row_i    (s_axis_tlast),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_row_o    (push_row)
  );

  dbf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_row_i   (push_row),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_row_o    (pop_row)
  );

  dbf_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_row_i   (pop_row),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tuser = res.found;
  assign m_axis_tdata = {7'b0, res.center_y, res.center_x, res.box_height, res.box_width,
                         res.box_top, res.box_left, res.confidence, res.label_id};

endmodule

// ===== tb/tb_detection_box_filter.sv =====
`timescale 1ns / 100ps

module tb_detection_box_filter;
  import dbf_pkg::*;

  localparam int FRAC         = COORD_FRAC_BITS_DEF;
  localparam int PHASES       = 10;
  localparam int PHASE_ROWS   = 175;
  localparam int FLUSH_CYCLES = 24;
  localparam int HOLDOFF_LEN  = 400;
  localparam int STALL_LIMIT  = 3000;

  // One detector row as the testbench builds it.
  typedef struct packed {
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic [SCORE_W-1:0]        score;
    logic [CLASS_VAL_W-1:0]    cval;
    logic                      last;
  } row_t;

  // Predicts the box of each frame and holds the results still to come.
  class box_predictor;
    dbf_cfg_t    cfg;
    bit          frame_done = 1'b0;
    dbf_result_t pending_boxes[$];
    int          errors = 0;

    // Register values after reset.
    function new();
      cfg.score_limit   = SCORE_W'(32768);
      cfg.inverse_scale = SCALE_W'(65536);
      cfg.offset_x      = '0;
      cfg.offset_y      = '0;
      cfg.image_width   = PIXEL_W'(1280);
      cfg.image_height  = PIXEL_W'(1024);
      cfg.single_class  = 1'b0;
    endfunction

    function void write_reg(dbf_reg_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_SCORE_LIMIT:   cfg.score_limit   = v[SCORE_W-1:0];
        REG_INVERSE_SCALE: cfg.inverse_scale = v[SCALE_W-1:0];
        REG_OFFSET_X:      cfg.offset_x      = v[PIXEL_W-1:0];
        REG_OFFSET_Y:      cfg.offset_y      = v[PIXEL_W-1:0];
        REG_IMAGE_WIDTH:   cfg.image_width   = v[PIXEL_W-1:0];
        REG_IMAGE_HEIGHT:  cfg.image_height  = v[PIXEL_W-1:0];
        REG_SINGLE_CLASS:  cfg.single_class  = v[0];
        default: ;
      endcase
    endfunction

    // Multiply by the inverse scale and drop its fraction, rounding down.
    function longint scale_edge(longint v);
      return (v * longint'(cfg.inverse_scale)) >>> SCALE_FRAC_W;
    endfunction

    function void clip_axis(input longint lo, input longint size, input longint lim,
                            output longint start, output longint len);
      longint s;
      longint e;
      s = (lo < lim) ? lo : lim;
      e = lo + size;
      if (s < 0) s = 0;
      if (e > lim) e = lim;
      if (e < s) e = s;
      start = s;
      len   = e - s;
    endfunction

    // Returns 1 when the row was looked at, 0 when the frame already had a box.
    function bit note_row(row_t r);
      longint      lft, rgt, top, bot, sl, st, sw, sh, cl, ct, cw, ch, cx, cy;
      int unsigned cls_round;
      dbf_result_t res;
      if (frame_done) begin
        if (r.last) frame_done = 1'b0;
        return 1'b0;
      end
      res = '0;
      if (cfg.inverse_scale != 0 && r.score >= cfg.score_limit) begin
        lft = (r.x1 < r.x2) ? longint'(r.x1) : longint'(r.x2);
        rgt = (r.x1 < r.x2) ? longint'(r.x2) : longint'(r.x1);
        top = (r.y1 < r.y2) ? longint'(r.y1) : longint'(r.y2);
        bot = (r.y1 < r.y2) ? longint'(r.y2) : longint'(r.y1);
        sl = scale_edge(lft) + (longint'(cfg.offset_x) << FRAC);
        st = scale_edge(top) + (longint'(cfg.offset_y) << FRAC);
        sw = scale_edge(rgt - lft);
        sh = scale_edge(bot - top);
        clip_axis(sl, sw, longint'(cfg.image_width) << FRAC, cl, cw);
        clip_axis(st, sh, longint'(cfg.image_height) << FRAC, ct, ch);
        if (cw > (longint'(1) << FRAC) && ch > (longint'(1) << FRAC)) begin
          cls_round = (int'(r.cval) + (1 << (CLASS_FRAC_BITS - 1))) >> CLASS_FRAC_BITS;
          if (cls_round > CLASS_MAX) cls_round = CLASS_MAX;
          cx = cl + (cw >>> 1);
          cy = ct + (ch >>> 1);
          res.found      = 1'b1;
          res.label_id   = cfg.single_class ? '1 : cls_round[CLASS_ID_W-1:0];
          res.confidence = r.score;
          res.box_left   = cl[COORD_W-1:0];
          res.box_top    = ct[COORD_W-1:0];
          res.box_width  = cw[COORD_W-1:0];
          res.box_height = ch[COORD_W-1:0];
          res.center_x   = cx[COORD_W-1:0];
          res.center_y   = cy[COORD_W-1:0];
          pending_boxes.push_back(res);
          frame_done = !r.last;
          return 1'b1;
        end
      end
      // A frame that ends without a box reports an all-zero result.
      if (r.last) pending_boxes.push_back(res);
      return 1'b1;
    endfunction

    function void compare_field(string name, logic [COORD_W-1:0] want,
                                logic [COORD_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_box(dbf_result_t got);
      dbf_result_t want;
      if (pending_boxes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual found=%b data=%h",
                 $time, got.found, got);
        errors++;
        return;
      end
      want = pending_boxes.pop_front();
      compare_field("found", want.found, got.found);
      compare_field("label_id", want.label_id, got.label_id);
      compare_field("confidence", want.confidence, got.confidence);
      compare_field("box_left", want.box_left, got.box_left);
      compare_field("box_top", want.box_top, got.box_top);
      compare_field("box_width", want.box_width, got.box_width);
      compare_field("box_height", want.box_height, got.box_height);
      compare_field("center_x", want.center_x, got.center_x);
      compare_field("center_y", want.center_y, got.center_y);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  row_valid = 1'b0;
  logic                  row_ready;
  logic [IN_DATA_W-1:0]  row_data = '0;
  logic                  row_last = 1'b0;
  logic                  box_valid;
  logic                  box_ready = 1'b0;
  logic [OUT_DATA_W-1:0] box_data;
  logic                  box_found;

  box_predictor sb;
  int           rows_used = 0;
  bit           holdoff_req = 1'b0;
  int           stall_cycles = 0;

  detection_box_filter #(
    .COORD_FRAC_BITS(FRAC)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(row_valid),
    .s_axis_tready(row_ready),
    .s_axis_tdata (row_data),
    .s_axis_tlast (row_last),
    .m_axis_tvalid(box_valid),
    .m_axis_tready(box_ready),
    .m_axis_tdata (box_data),
    .m_axis_tuser (box_found)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Check every result transfer and watch for a stalled run.
  always @(posedge clk_i) begin
    dbf_result_t got;
    if (rst_ni && box_valid && box_ready) begin
      got.found      = box_found;
      got.label_id   = box_data[8:0];
      got.confidence = box_data[24:9];
      got.box_left   = box_data[40:25];
      got.box_top    = box_data[56:41];
      got.box_width  = box_data[72:57];
      got.box_height = box_data[88:73];
      got.center_x   = box_data[104:89];
      got.center_y   = box_data[120:105];
      sb.check_box(got);
    end
    if ((row_valid && row_ready) || (box_valid && box_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: stall patterns that change now and then, plus one long hold-off.
  initial begin
    int mode;
    int left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        box_ready <= 1'b0;
        repeat (HOLDOFF_LEN) @(posedge clk_i);
        holdoff_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: box_ready <= 1'b1;
          1: box_ready <= 1'($urandom_range(0, 1));
          2: box_ready <= ($urandom_range(0, 7) == 0);
          default: box_ready <= (left % 5 != 0);
        endcase
      end
    end
  end

  function automatic row_t mk_row(int x1, int y1, int x2, int y2, int score, int cval,
                                  bit last);
    row_t r;
    r.x1    = x1[COORD_W-1:0];
    r.y1    = y1[COORD_W-1:0];
    r.x2    = x2[COORD_W-1:0];
    r.y2    = y2[COORD_W-1:0];
    r.score = score[SCORE_W-1:0];
    r.cval  = cval[CLASS_VAL_W-1:0];
    r.last  = last;
    return r;
  endfunction

  // Mostly plausible boxes that pass the score limit; sometimes anything at all.
  function automatic row_t random_row(bit wild, bit last);
    row_t r;
    int   x, y, w, h;
    if (wild) begin
      r = mk_row($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 1'($urandom_range(0, 1)));
    end else begin
      x = int'($urandom_range(0, 12000)) - 1000;
      y = int'($urandom_range(0, 12000)) - 1000;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4000);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4000);
      r = mk_row(x, y, x + w, y + h,
                 ($urandom_range(0, 3) == 0) ? $urandom
                                             : $urandom_range(sb.cfg.score_limit, 65535),
                 $urandom, last);
      if ($urandom_range(0, 1)) begin
        r.x1 = r.x2;
        r.x2 = x[COORD_W-1:0];
      end
      if ($urandom_range(0, 1)) begin
        r.y1 = r.y2;
        r.y2 = y[COORD_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic dbf_cfg_t make_cfg(int score, int scale, int offx, int offy,
                                        int w, int h, bit single);
    dbf_cfg_t c;
    c.score_limit   = score[SCORE_W-1:0];
    c.inverse_scale = scale[SCALE_W-1:0];
    c.offset_x      = offx[PIXEL_W-1:0];
    c.offset_y      = offy[PIXEL_W-1:0];
    c.image_width   = w[PIXEL_W-1:0];
    c.image_height  = h[PIXEL_W-1:0];
    c.single_class  = single;
    return c;
  endfunction

  task automatic write_reg(dbf_reg_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, v);
  endtask

  // Back-to-back writes of all registers; valid drops after the last transfer.
  task automatic program_regs(dbf_cfg_t c);
    write_reg(REG_SCORE_LIMIT, CFG_DATA_W'(c.score_limit));
    write_reg(REG_INVERSE_SCALE, CFG_DATA_W'(c.inverse_scale));
    write_reg(REG_OFFSET_X, CFG_DATA_W'(c.offset_x));
    write_reg(REG_OFFSET_Y, CFG_DATA_W'(c.offset_y));
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(c.image_width));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(c.image_height));
    write_reg(REG_SINGLE_CLASS, CFG_DATA_W'(c.single_class));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_row(row_t r);
    row_valid <= 1'b1;
    row_data  <= {4'b0, r.cval, r.score, r.y2, r.x2, r.y1, r.x1};
    row_last  <= r.last;
    do @(posedge clk_i); while (!row_ready);
    void'(sb.note_row(r));
    rows_used++;
  endtask

  task automatic rest(int n);
    if (n > 0) begin
      row_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Sender stays quiet until every predicted result has come back.
  task automatic wait_results_done();
    row_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_boxes.size() != 0);
  endtask

  // Rows that give no result may still be in the pipeline; let them pass.
  task automatic drain();
    wait_results_done();
    repeat (FLUSH_CYCLES) @(posedge clk_i);
  endtask

  task automatic directed_rows();
    program_regs(make_cfg(32768, 65536, 0, 0, 1280, 1024, 0));
    // Plain box, then a row after the find that only closes the frame.
    send_row(mk_row(1600, 1600, 4800, 3200, 65535, 0, 0));
    send_row(mk_row(0, 0, 3200, 3200, 65535, 0, 1));
    // Swapped corners, class rounding that saturates, find on the last row.
    send_row(mk_row(4800, 3200, 1600, 1600, 40000, 4095, 1));
    // Score just below and exactly at the limit.
    send_row(mk_row(1600, 1600, 4800, 3200, 32767, 16, 1));
    send_row(mk_row(1600, 1600, 4800, 3200, 32768, 7, 1));
    // Width of exactly one pixel, then just over one pixel.
    send_row(mk_row(1600, 1600, 1616, 3200, 65535, 8, 1));
    send_row(mk_row(1600, 1600, 1617, 3200, 65535, 8, 1));
    // Corner extremes: clipped to the whole image, and entirely off the image.
    send_row(mk_row(-32768, -32768, 32767, 32767, 65535, 24, 1));
    send_row(mk_row(-32768, -32768, -16000, -100, 65535, 0, 1));
    // Rejected rows ahead of the find, then an ignored last row.
    send_row(mk_row(1600, 1600, 4800, 3200, 100, 0, 0));
    send_row(mk_row(1600, 1600, 1610, 3200, 65535, 0, 0));
    send_row(mk_row(32767, 32767, 20000, 16000, 65535, 300, 0));
    send_row(mk_row(1600, 1600, 4800, 3200, 65535, 0, 1));
    // Single-class mode with the largest scale, offsets and image.
    drain();
    program_regs(make_cfg(0, 16777215, 4095, 4095, 4095, 4095, 1));
    send_row(mk_row(-1000, -1000, 1000, 1000, 0, 100, 1));
    send_row(mk_row(0, 0, 2, 2, 65535, 100, 1));
    // Zero inverse scale rejects every row.
    drain();
    program_regs(make_cfg(0, 0, 0, 0, 1280, 1024, 0));
    send_row(mk_row(1600, 1600, 4800, 3200, 65535, 0, 1));
    // Zero image size clips every box away.
    drain();
    program_regs(make_cfg(0, 65536, 0, 0, 0, 0, 0));
    send_row(mk_row(1600, 1600, 4800, 3200, 0, 0, 1));
    drain();
    program_regs(make_cfg(0, 65536, 0, 0, 1, 1, 0));
    send_row(mk_row(-1600, -1600, 4800, 3200, 65535, 0, 1));
  endtask

  function automatic dbf_cfg_t phase_cfg(int phase);
    case (phase)
      0: return make_cfg(32768, 65536, 0, 0, 1280, 1024, 0);
      1: return make_cfg(0, 16777215, 4095, 4095, 4095, 4095, 1);
      2: return make_cfg(65535, 0, 0, 0, 1, 1, 0);
      3: return make_cfg(0, 1, 0, 0, 4095, 4095, 1);
      7: return make_cfg($urandom, $urandom, $urandom, $urandom, $urandom_range(1, 4095),
                         $urandom_range(1, 4095), 1'($urandom_range(0, 1)));
      default: return make_cfg($urandom_range(0, 45000), $urandom_range(20000, 200000),
                               $urandom_range(0, 400), $urandom_range(0, 400),
                               $urandom_range(320, 4095), $urandom_range(320, 4095),
                               1'($urandom_range(0, 1)));
    endcase
  endfunction

  // Frames of random length in bursts; a few frames are pure noise.
  task automatic random_rows(int phase);
    int start_used;
    int burst;
    int frame_len;
    bit wild_frame;
    bit no_gaps;
    bit pressure_done;
    start_used    = rows_used;
    burst         = $urandom_range(1, 30);
    no_gaps       = (phase % 3 == 2);
    pressure_done = 1'b0;
    while (rows_used - start_used < PHASE_ROWS) begin
      frame_len  = $urandom_range(1, 6);
      wild_frame = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < frame_len; k++) begin
        send_row(random_row(wild_frame || $urandom_range(0, 15) == 0, k == frame_len - 1));
        if (!pressure_done && rows_used - start_used >= 40) begin
          pressure_done = 1'b1;
          if (phase == 4) holdoff_req = 1'b1;
          if (phase == 6) wait_results_done();
        end
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 30);
          if (!no_gaps && !holdoff_req) rest($urandom_range(1, 12));
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_rows();
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      program_regs(phase_cfg(phase));
      random_rows(phase);
    end
    drain();
    if (sb.errors == 0 && sb.pending_boxes.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
